// ===== sv/fpsd_pkg.sv =====
// ----------------------------------------------------------------------------
// fpsd_pkg
// Shared types and constants for the fixed predictor subframe decoder.
// ----------------------------------------------------------------------------
package fpsd_pkg;

   // Default widths of the sample path
   localparam int DEF_INPUT_BITS  = 16;
   localparam int DEF_OUTPUT_BITS = 32;

   // Port widths fixed by the register map and the result format
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int SAMPLE_BITS    = 32;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_METHOD         = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PREDICTOR_ORDER = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLOCK_LENGTH   = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONSTANT_LEVEL = 2'd3;

   // Coding methods (code 3 decodes as verbatim)
   localparam logic [1:0] METHOD_VERBATIM = 2'd0;
   localparam logic [1:0] METHOD_CONSTANT = 2'd1;
   localparam logic [1:0] METHOD_FIXED    = 2'd2;

   localparam logic [2:0] MAX_ORDER = 3'd4;

   // Reset values of the registers
   localparam logic [1:0]         RST_METHOD         = METHOD_VERBATIM;
   localparam logic [2:0]         RST_PREDICTOR_ORDER = 3'd2;
   localparam logic [15:0]        RST_BLOCK_LENGTH   = 16'd4096;
   localparam logic signed [15:0] RST_CONSTANT_LEVEL = 16'sd0;

   typedef struct packed {
      logic [1:0]         method;
      logic [2:0]         predictor_order;
      logic [15:0]        block_length;
      logic signed [15:0] constant_level;
   } cfg_type;

endpackage

// ===== sv/fpsd_csr.sv =====
// ----------------------------------------------------------------------------
// fpsd_csr
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module fpsd_csr
   import fpsd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_METHOD:          cfg_in.method          = csr_wdata[1:0];
            CSR_PREDICTOR_ORDER: cfg_in.predictor_order = csr_wdata[2:0];
            CSR_BLOCK_LENGTH:    cfg_in.block_length    = csr_wdata[15:0];
            CSR_CONSTANT_LEVEL:  cfg_in.constant_level  = signed'(csr_wdata[15:0]);
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.method          <= RST_METHOD;
         cfg_ff.predictor_order <= RST_PREDICTOR_ORDER;
         cfg_ff.block_length    <= RST_BLOCK_LENGTH;
         cfg_ff.constant_level  <= RST_CONSTANT_LEVEL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/fpsd_recon.sv =====
// ----------------------------------------------------------------------------
// fpsd_recon
// Sample reconstruction: history, block position and fixed prediction.
// ----------------------------------------------------------------------------
module fpsd_recon
   import fpsd_pkg::*;
#(
   parameter int INPUT_BITS  = DEF_INPUT_BITS,
   parameter int OUTPUT_BITS = DEF_OUTPUT_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic                          advance,
   input  logic signed [INPUT_BITS-1:0]  value,
   output logic signed [SAMPLE_BITS-1:0] sample,
   output logic                          last
);

   logic [OUTPUT_BITS-1:0] history_ff [4];
   logic [15:0]            position_ff;
   logic [15:0]            position_in;

   logic [2:0]             order_eff;
   logic [16:0]            length_eff;
   logic [16:0]            position_inc;
   logic [SAMPLE_BITS-1:0] value_ext;
   logic [SAMPLE_BITS-1:0] const_ext;
   logic [OUTPUT_BITS-1:0] value_ob;
   logic [OUTPUT_BITS-1:0] const_ob;
   logic [OUTPUT_BITS-1:0] predict;
   logic [OUTPUT_BITS-1:0] sample_ob;
   logic                   warm_up;

   assign order_eff  = (cfg.predictor_order > MAX_ORDER) ? MAX_ORDER : cfg.predictor_order;
   // zero length stands for a full 65536-sample block
   assign length_eff = (cfg.block_length == 16'd0) ? 17'h10000 : {1'b0, cfg.block_length};
   assign position_inc = {1'b0, position_ff} + 17'd1;
   assign last = (position_inc >= length_eff);
   assign position_in = last ? 16'd0 : position_inc[15:0];
   assign warm_up = (position_ff < {13'd0, order_eff});

   assign value_ext = SAMPLE_BITS'(value);
   assign const_ext = SAMPLE_BITS'(cfg.constant_level);
   assign value_ob  = value_ext[OUTPUT_BITS-1:0];
   assign const_ob  = const_ext[OUTPUT_BITS-1:0];

   // polynomial prediction over up to the newest four samples, wrapping
   always_comb begin
      case (order_eff)
         3'd0: predict = '0;
         3'd1: predict = history_ff[0];
         3'd2: predict = (history_ff[0] << 1) - history_ff[1];
         3'd3: predict = (history_ff[0] << 1) + history_ff[0]
                       - ((history_ff[1] << 1) + history_ff[1]) + history_ff[2];
         default: predict = (history_ff[0] << 2)
                          - ((history_ff[1] << 2) + (history_ff[1] << 1))
                          + (history_ff[2] << 2) - history_ff[3];
      endcase
   end

   always_comb begin
      case (cfg.method)
         METHOD_CONSTANT: sample_ob = const_ob;
         METHOD_FIXED:    sample_ob = warm_up ? value_ob : (predict + value_ob);
         default:         sample_ob = value_ob;
      endcase
   end

   assign sample = SAMPLE_BITS'(signed'(sample_ob));

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff[0] <= '0;
         history_ff[1] <= '0;
         history_ff[2] <= '0;
         history_ff[3] <= '0;
         position_ff   <= '0;
      end else if (advance) begin
         history_ff[3] <= history_ff[2];
         history_ff[2] <= history_ff[1];
         history_ff[1] <= history_ff[0];
         history_ff[0] <= sample_ob;
         position_ff   <= position_in;
      end
   end

endmodule

// ===== sv/fixed_predictor_subframe_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// fixed_predictor_subframe_decoder_unit
// Rebuilds subframe samples from verbatim, constant or fixed-predicted data.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_stall/req_value carry one 16-bit value per transaction:
//   a verbatim sample, a warm-up sample or a residual.
//   rsp_valid/rsp_stall/rsp_sample/rsp_last return one 32-bit sample per
//   transaction; rsp_last marks the final sample of a block.
//   csr_write/csr_index/csr_wdata set method, predictor order, block length
//   and constant level; write them only while the block is idle.
// Timing:
//   A taken value is registered in the input stage, rebuilt from the history
//   and moved to the result register (rsp_valid) once that is free or moving
//   on. One transaction per cycle is sustained while rsp_stall is low; the
//   limit is the single prediction adder path between the two registers.
// Reset: clears the registers to their defaults, the history to zero, the
//   block position to zero and both pipeline stages to empty.
// Stall: a stalled result holds; the input stage keeps taking a value as
//   long as its own slot is free or moving on, otherwise req_stall rises.
// ----------------------------------------------------------------------------
module fixed_predictor_subframe_decoder_unit
   import fpsd_pkg::*;
#(
   parameter int INPUT_BITS  = DEF_INPUT_BITS,
   parameter int OUTPUT_BITS = DEF_OUTPUT_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [INPUT_BITS-1:0]  req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample,
   output logic                          rsp_last,
   input  logic                          csr_write,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   cfg_type cfg;

   logic                          in_valid_ff;
   logic                          in_valid_in;
   logic signed [INPUT_BITS-1:0]  in_value_ff;
   logic                          out_valid_ff;
   logic                          out_valid_in;
   logic signed [SAMPLE_BITS-1:0] out_sample_ff;
   logic                          out_last_ff;

   logic                          req_take;
   logic                          rsp_take;
   logic                          advance;
   logic signed [SAMPLE_BITS-1:0] recon_sample;
   logic                          recon_last;

   fpsd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fpsd_recon #(
      .INPUT_BITS  (INPUT_BITS),
      .OUTPUT_BITS (OUTPUT_BITS)
   ) u_recon (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .advance (advance),
      .value   (in_value_ff),
      .sample  (recon_sample),
      .last    (recon_last)
   );

   assign rsp_take  = out_valid_ff && !rsp_stall;
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_value_ff <= req_value;
      end
      if (advance) begin
         out_sample_ff <= recon_sample;
         out_last_ff   <= recon_last;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_sample = out_sample_ff;
   assign rsp_last   = out_last_ff;

endmodule

// ===== sv/fpsd_checker.sv =====
// ----------------------------------------------------------------------------
// fpsd_checker
// Port-level checks for the fixed predictor subframe decoder.
// ----------------------------------------------------------------------------
module fpsd_checker
   import fpsd_pkg::*;
(
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [SAMPLE_BITS-1:0] rsp_sample,
   input logic                          rsp_last
);

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // every accepted transaction is followed by rsp_valid high
   assert property (@(posedge clock) disable iff (reset)
                    (req_valid && !req_stall) |=> ##1 rsp_valid)
      else $error("accepted transaction produced no result");

   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && rsp_stall) |=> ($stable(rsp_sample) && $stable(rsp_last)))
      else $error("stalled result changed");

endmodule

bind fixed_predictor_subframe_decoder_unit fpsd_checker u_fpsd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_sample (rsp_sample),
   .rsp_last   (rsp_last)
);
